### hdl/packed_pixel_cursor_plotter_assert.svh
// Assertion macros for the packed-pixel cursor plotter checker
`ifndef PACKED_PIXEL_CURSOR_PLOTTER_ASSERT_SVH
`define PACKED_PIXEL_CURSOR_PLOTTER_ASSERT_SVH

// Check a consequence in the same cycle
`define PPCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the next cycle
`define PPCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ppcp_pkg.sv
// Shared constants and types for the packed-pixel cursor plotter
package ppcp_pkg;

  localparam int FRAME_BYTES    = 65536;
  localparam int ADDR_BITS      = $clog2(FRAME_BYTES);
  localparam int LANES          = 4;
  localparam int LANE_BITS      = $clog2(LANES);
  localparam int ROW_BITS       = ADDR_BITS - LANE_BITS;
  localparam int MEM_ROWS       = FRAME_BYTES / LANES;
  localparam int COORD_BITS     = 16;
  localparam int XW             = COORD_BITS + 1;
  localparam int BPL_BITS       = 13;
  localparam int PROD_BITS      = COORD_BITS + BPL_BITS + 1;
  localparam int OFFSET_BITS    = 32;
  localparam int BITPOS_BITS    = 5;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [1:0]          RST_PACKING  = 2'd0;
  localparam logic [BPL_BITS-1:0] RST_BPL      = 13'd320;
  localparam logic signed [15:0]  RST_CLIP_L   = 16'sd0;
  localparam logic signed [15:0]  RST_CLIP_R   = 16'sd319;
  localparam logic signed [15:0]  RST_CLIP_T   = 16'sd0;
  localparam logic signed [15:0]  RST_CLIP_B   = 16'sd239;
  localparam logic [7:0]          RST_FG       = 8'd255;
  localparam logic [7:0]          RST_BG       = 8'd0;
  localparam logic [3:0]          RST_SHIFT    = 4'd8;
  localparam logic [7:0]          RST_MASK     = 8'd255;

  typedef enum logic [2:0] {
    FN_MOVE  = 3'd0,
    FN_PLOT  = 3'd1,
    FN_UP    = 3'd2,
    FN_DOWN  = 3'd3,
    FN_LEFT  = 3'd4,
    FN_RIGHT = 3'd5,
    FN_WORD  = 3'd6,
    FN_NOP   = 3'd7
  } func_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PACKING = 3'd0,
    REG_BPL     = 3'd1,
    REG_CLIP_L  = 3'd2,
    REG_CLIP_R  = 3'd3,
    REG_CLIP_T  = 3'd4,
    REG_CLIP_B  = 3'd5,
    REG_FG      = 3'd6,
    REG_BG      = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MOP_NONE  = 2'd0,
    MOP_BYTE  = 2'd1,
    MOP_MERGE = 2'd2,
    MOP_WORD  = 2'd3
  } mem_op_t;

  typedef struct packed {
    mem_op_t                       op;
    logic [ADDR_BITS-1:0]          addr;
    logic [7:0]                    colour;
    logic [7:0]                    mask;
    logic [2:0]                    shift;
    logic [31:0]                   word;
    logic signed [COORD_BITS-1:0]  cur_x;
    logic signed [COORD_BITS-1:0]  cur_y;
    logic                          in_clip;
  } mem_cmd_t;

endpackage

### hdl/packed_pixel_cursor_plotter.sv
// Packed-pixel drawing cursor with clipped plot and word store over a cleared framebuffer
//
//  Channel | Ports                                   | Transfer
//  --------+-----------------------------------------+-------------------------------
//  input   | in_valid / in_ready, in_* fields        | in_valid & in_ready at clk edge
//  result  | out_valid / out_ready, out_* fields     | out_valid & out_ready at clk edge
//  config  | cfg_write_en, cfg_index, cfg_data       | cfg_write_en at clk edge
//
// One command per cycle while in_ready is high; commands pass the memory stage, then the
// result register. A word store at a byte offset that is not a multiple of four writes
// one row, then the next, as its bytes span two rows of the single-write-port framebuffer
// memory. After reset a clearing pass writes all FRAME_BYTES/4 rows with in_ready low;
// configuration writes are taken throughout. With out_ready low the result register
// holds, one command waits in the memory stage, then in_ready falls.
module packed_pixel_cursor_plotter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           in_func,
  input  logic signed [15:0]                   in_target_x,
  input  logic signed [15:0]                   in_target_y,
  input  logic                                 in_use_foreground,
  input  logic [31:0]                          in_colour_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [15:0]                   out_cursor_x,
  output logic signed [15:0]                   out_cursor_y,
  output logic                                 out_inside_clip,
  output logic                                 out_write_valid,
  output logic                                 out_write_is_word,
  output logic [15:0]                          out_write_address,
  output logic [31:0]                          out_write_data,
  input  logic                                 cfg_write_en,
  input  logic [ppcp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [ppcp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import ppcp_pkg::*;

  logic [1:0]                    packing_r;
  logic [BPL_BITS-1:0]           bpl_r;
  logic signed [15:0]            clip_l_r, clip_r_r, clip_t_r, clip_b_r;
  logic [7:0]                    fg_r, bg_r;

  logic signed [COORD_BITS-1:0]  pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [OFFSET_BITS-1:0]        off_r, off_nxt;
  logic signed [BITPOS_BITS-1:0] bitpos_r, bitpos_nxt;
  logic                          h_in_r, h_in_nxt, v_in_r, v_in_nxt;
  logic [3:0]                    shift_r, shift_nxt;
  logic [7:0]                    mask_r, mask_nxt;

  logic                          clr_busy_r;
  logic [ROW_BITS-1:0]           clr_row_r;

  logic                          p_valid_r, p_phase_r;
  mem_cmd_t                      p_r, cmd;

  logic                          byp_valid_r;
  logic [ROW_BITS-1:0]           byp_row_r;
  logic [LANES-1:0]              byp_be_r;
  logic [31:0]                   byp_data_r;

  logic [31:0]                   mem [MEM_ROWS];
  logic [31:0]                   rdata_r;
  logic [ROW_BITS-1:0]           rd_row;

  logic                          wr_en;
  logic [ROW_BITS-1:0]           wr_row;
  logic [LANES-1:0]              wr_be;
  logic [31:0]                   wr_data;

  logic                          out_valid_r, out_inside_r, out_wv_r, out_word_r;
  logic signed [15:0]            out_x_r, out_y_r;
  logic [15:0]                   out_addr_r;
  logic [31:0]                   out_data_r;

  logic                          accept, out_free, p_two, p_done;
  func_t                         func;

  logic signed [COORD_BITS-1:0]  mv_x, mv_y;
  logic signed [XW-1:0]          mv_x_ext, x_bias, x_quot, x_rem_full;
  logic [2:0]                    ppb_m1;
  logic [3:0]                    x_rem;
  logic signed [PROD_BITS-1:0]   y_scaled;
  logic [OFFSET_BITS-1:0]        off_mv;
  logic signed [BITPOS_BITS-1:0] bitpos_mv, bp_dec, bp_inc;
  logic [7:0]                    mask_mv;
  logic                          upd_h, upd_v;

  logic [ROW_BITS-1:0]           p_row0, p_row1;
  logic [LANE_BITS-1:0]          p_lane;
  logic [LANES-1:0]              be0;
  logic [63:0]                   rot_wide;
  logic [31:0]                   rot_word, merged;
  logic [15:0]                   mask_wide, col_wide;
  logic [7:0]                    old_byte, new_byte;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packing_r <= RST_PACKING;
      bpl_r     <= RST_BPL;
      clip_l_r  <= RST_CLIP_L;
      clip_r_r  <= RST_CLIP_R;
      clip_t_r  <= RST_CLIP_T;
      clip_b_r  <= RST_CLIP_B;
      fg_r      <= RST_FG;
      bg_r      <= RST_BG;
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PACKING: packing_r <= cfg_data[1:0];
        REG_BPL:     bpl_r     <= cfg_data[BPL_BITS-1:0];
        REG_CLIP_L:  clip_l_r  <= cfg_data;
        REG_CLIP_R:  clip_r_r  <= cfg_data;
        REG_CLIP_T:  clip_t_r  <= cfg_data;
        REG_CLIP_B:  clip_b_r  <= cfg_data;
        REG_FG:      fg_r      <= cfg_data[7:0];
        REG_BG:      bg_r      <= cfg_data[7:0];
      endcase
    end
  end

  assign func     = func_t'(in_func);
  assign out_free = !out_valid_r || out_ready;
  assign p_two    = p_valid_r && (p_r.op == MOP_WORD) && (p_lane != '0);
  assign p_done   = p_valid_r && out_free && (!p_two || p_phase_r);
  assign in_ready = !clr_busy_r && (!p_valid_r || p_done);
  assign accept   = in_valid && in_ready;

  // absolute move: truncating divide and remainder by pixels per byte
  assign mv_x       = COORD_BITS'(in_target_x);
  assign mv_y       = COORD_BITS'(in_target_y);
  assign mv_x_ext   = XW'(mv_x);
  assign ppb_m1     = 3'((4'd1 << packing_r) - 4'd1);
  assign x_bias     = mv_x_ext + ((mv_x < 0) ? XW'(ppb_m1) : XW'(0));
  assign x_quot     = x_bias >>> packing_r;
  assign x_rem_full = mv_x_ext - (x_quot <<< packing_r);
  assign x_rem      = x_rem_full[3:0];
  assign bitpos_mv  = {x_rem[3], x_rem} << (2'd3 - packing_r);
  assign y_scaled   = mv_y * $signed({1'b0, bpl_r});
  assign off_mv     = OFFSET_BITS'(x_quot) + OFFSET_BITS'(y_scaled);
  assign bp_dec     = bitpos_r - $signed({1'b0, shift_r});
  assign bp_inc     = bitpos_r + $signed({1'b0, shift_r});

  always_comb begin
    unique case (packing_r)
      2'd0:    mask_mv = 8'd255;
      2'd1:    mask_mv = 8'd15;
      2'd2:    mask_mv = 8'd3;
      default: mask_mv = 8'd1;
    endcase
  end

  // cursor next state
  always_comb begin
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    off_nxt    = off_r;
    bitpos_nxt = bitpos_r;
    shift_nxt  = shift_r;
    mask_nxt   = mask_r;
    upd_h      = 1'b0;
    upd_v      = 1'b0;
    unique case (func)
      FN_MOVE: begin
        pos_x_nxt  = mv_x;
        pos_y_nxt  = mv_y;
        off_nxt    = off_mv;
        bitpos_nxt = bitpos_mv;
        shift_nxt  = 4'd8 >> packing_r;
        mask_nxt   = mask_mv;
        upd_h      = 1'b1;
        upd_v      = 1'b1;
      end
      FN_PLOT: begin
      end
      FN_UP: begin
        off_nxt   = off_r - OFFSET_BITS'(bpl_r);
        pos_y_nxt = pos_y_r - 1'b1;
        upd_v     = 1'b1;
      end
      FN_DOWN: begin
        off_nxt   = off_r + OFFSET_BITS'(bpl_r);
        pos_y_nxt = pos_y_r + 1'b1;
        upd_v     = 1'b1;
      end
      FN_LEFT: begin
        pos_x_nxt = pos_x_r - 1'b1;
        upd_h     = 1'b1;
        if (bp_dec < 0) begin
          bitpos_nxt = bp_dec + 5'sd8;
          off_nxt    = off_r - 1'b1;
        end else begin
          bitpos_nxt = bp_dec;
        end
      end
      FN_RIGHT: begin
        pos_x_nxt = pos_x_r + 1'b1;
        upd_h     = 1'b1;
        if (bp_inc == 5'sd8) begin
          bitpos_nxt = '0;
          off_nxt    = off_r + 1'b1;
        end else begin
          bitpos_nxt = bp_inc;
        end
      end
      FN_WORD: begin
        off_nxt   = off_r + OFFSET_BITS'(4);
        pos_x_nxt = pos_x_r + COORD_BITS'(6'd4 << packing_r);
        upd_h     = 1'b1;
      end
      FN_NOP: begin
      end
    endcase
    h_in_nxt = upd_h ? ((pos_x_nxt >= clip_l_r) && (pos_x_nxt <= clip_r_r)) : h_in_r;
    v_in_nxt = upd_v ? ((pos_y_nxt >= clip_t_r) && (pos_y_nxt <= clip_b_r)) : v_in_r;
  end

  // command for the memory stage
  always_comb begin
    cmd.op = MOP_NONE;
    if (func == FN_PLOT && h_in_r && v_in_r) begin
      cmd.op = (packing_r == 2'd0) ? MOP_BYTE : MOP_MERGE;
    end else if (func == FN_WORD) begin
      cmd.op = MOP_WORD;
    end
    cmd.addr    = off_r[ADDR_BITS-1:0];
    cmd.colour  = in_use_foreground ? fg_r : bg_r;
    cmd.mask    = mask_r;
    cmd.shift   = bitpos_r[2:0];
    cmd.word    = in_colour_word;
    cmd.cur_x   = pos_x_nxt;
    cmd.cur_y   = pos_y_nxt;
    cmd.in_clip = h_in_nxt && v_in_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      off_r    <= '0;
      bitpos_r <= '0;
      h_in_r   <= 1'b0;
      v_in_r   <= 1'b0;
      shift_r  <= RST_SHIFT;
      mask_r   <= RST_MASK;
    end else if (accept) begin
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
      off_r    <= off_nxt;
      bitpos_r <= bitpos_nxt;
      h_in_r   <= h_in_nxt;
      v_in_r   <= v_in_nxt;
      shift_r  <= shift_nxt;
      mask_r   <= mask_nxt;
    end
  end

  // memory stage
  assign rd_row   = off_r[ADDR_BITS-1:LANE_BITS];
  assign p_row0   = p_r.addr[ADDR_BITS-1:LANE_BITS];
  assign p_row1   = p_row0 + 1'b1;
  assign p_lane   = p_r.addr[LANE_BITS-1:0];
  assign be0      = 4'b1111 << p_lane;
  assign rot_wide = {p_r.word, p_r.word} << {p_lane, 3'b000};
  assign rot_word = rot_wide[63:32];

  // take the latest write for a row read in the same cycle
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      merged[8*j +: 8] = (byp_valid_r && byp_row_r == p_row0 && byp_be_r[j])
                       ? byp_data_r[8*j +: 8] : rdata_r[8*j +: 8];
    end
  end

  assign old_byte  = merged[8*p_lane +: 8];
  assign mask_wide = 16'(p_r.mask) << p_r.shift;
  assign col_wide  = 16'(p_r.colour & p_r.mask) << p_r.shift;
  assign new_byte  = (p_r.op == MOP_BYTE) ? p_r.colour
                   : ((old_byte & ~mask_wide[7:0]) | col_wide[7:0]);

  always_comb begin
    wr_en   = 1'b0;
    wr_row  = p_row0;
    wr_be   = be0;
    wr_data = rot_word;
    if (clr_busy_r) begin
      wr_en   = 1'b1;
      wr_row  = clr_row_r;
      wr_be   = '1;
      wr_data = '0;
    end else if (p_two && !p_phase_r) begin
      wr_en = 1'b1;
    end else if (p_done) begin
      case (p_r.op) inside
        MOP_BYTE, MOP_MERGE: begin
          wr_en   = 1'b1;
          wr_be   = LANES'(1) << p_lane;
          wr_data = {LANES{new_byte}};
        end
        MOP_WORD: begin
          wr_en = 1'b1;
          if (p_phase_r) begin
            wr_row = p_row1;
            wr_be  = ~be0;
          end
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int j = 0; j < LANES; j++) begin
        if (wr_be[j]) begin
          mem[wr_row][8*j +: 8] <= wr_data[8*j +: 8];
        end
      end
    end
    if (accept) begin
      rdata_r <= mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_row_r   <= '0;
      byp_valid_r <= 1'b0;
      p_valid_r   <= 1'b0;
      p_phase_r   <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_row_r <= clr_row_r + 1'b1;
        if (clr_row_r == ROW_BITS'(MEM_ROWS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end else if (wr_en) begin
        byp_valid_r <= 1'b1;
      end
      if (accept) begin
        p_valid_r <= 1'b1;
        p_phase_r <= 1'b0;
      end else if (p_done) begin
        p_valid_r <= 1'b0;
        p_phase_r <= 1'b0;
      end else if (p_two && !p_phase_r) begin
        p_phase_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !clr_busy_r) begin
      byp_row_r  <= wr_row;
      byp_be_r   <= wr_be;
      byp_data_r <= wr_data;
    end
    if (accept) begin
      p_r <= cmd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_done) begin
      out_x_r      <= 16'(p_r.cur_x);
      out_y_r      <= 16'(p_r.cur_y);
      out_inside_r <= p_r.in_clip;
      out_wv_r     <= (p_r.op != MOP_NONE);
      out_word_r   <= (p_r.op == MOP_WORD);
      out_addr_r   <= (p_r.op != MOP_NONE) ? 16'(p_r.addr) : 16'd0;
      case (p_r.op) inside
        MOP_BYTE, MOP_MERGE: out_data_r <= {24'd0, new_byte};
        MOP_WORD:            out_data_r <= p_r.word;
        default:             out_data_r <= '0;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_x      = out_x_r;
  assign out_cursor_y      = out_y_r;
  assign out_inside_clip   = out_inside_r;
  assign out_write_valid   = out_wv_r;
  assign out_write_is_word = out_word_r;
  assign out_write_address = out_addr_r;
  assign out_write_data    = out_data_r;

endmodule

### hdl/ppcp_checker.sv
// Port-level checks for the packed-pixel cursor plotter, bound to the top level
`include "packed_pixel_cursor_plotter_assert.svh"

module ppcp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_inside_clip,
  input logic        out_write_valid,
  input logic        out_write_is_word,
  input logic [15:0] out_write_address,
  input logic [31:0] out_write_data
);

  `PPCP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped before transfer")
  `PPCP_ASSERT_NOW(a_no_write_zero, out_valid && !out_write_valid, !out_write_is_word && out_write_address == 16'd0 && out_write_data == 32'd0, "write fields set without a write")
  `PPCP_ASSERT_NOW(a_plot_clipped, out_valid && out_write_valid && !out_write_is_word, out_inside_clip && out_write_data[31:8] == 24'd0, "byte write outside clip window")
  `PPCP_ASSERT_NOW(a_clear_after_reset, !$past(rst_n), !in_ready, "input taken during clearing pass")

endmodule

bind packed_pixel_cursor_plotter ppcp_checker u_ppcp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_inside_clip   (out_inside_clip),
  .out_write_valid   (out_write_valid),
  .out_write_is_word (out_write_is_word),
  .out_write_address (out_write_address),
  .out_write_data    (out_write_data)
);
